/* rtl/downlink_command_resend_queue_assert.svh */
// Assertion macros shared by the checker of downlink_command_resend_queue.
// No dependencies; included by files that hold concurrent assertions.
`ifndef DOWNLINK_COMMAND_RESEND_QUEUE_ASSERT_SVH
`define DOWNLINK_COMMAND_RESEND_QUEUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DCRQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dcrq assertion failed");

// Implication checked at the following clock edge.
`define DCRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dcrq assertion failed");

`endif

/* rtl/dcrq_pkg.sv */
// Shared types and constants for the downlink command resend queue.
// No dependencies; used by the top level, controller and datapath through scoped names.
package dcrq_pkg;

	localparam int OPCODE_W = 3;
	localparam int CLASS_W  = 2;
	localparam int VALUE_W  = 16;
	localparam int ENTRY_W  = VALUE_W + 1;	// dest bit on top of the value
	localparam int CFG_IDX_W = 2;

	localparam logic [OPCODE_W-1:0] OP_HOST     = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_LOCAL    = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TGT_RES  = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_HEAD_RES = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_LINK_UP  = 3'd4;

	localparam logic [CLASS_W-1:0] CLASS_TARGET = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_CTRL   = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_SORT   = 2'd2;

	localparam logic DEST_CTRL = 1'b0;
	localparam logic DEST_SORT = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LIMIT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SORT_LIMIT   = 2'd2;

	localparam logic [VALUE_W-1:0] RST_ALLOWED_MASK = 16'd7;
	localparam logic [VALUE_W-1:0] RST_TARGET_LIMIT = 16'd999;
	localparam logic [VALUE_W-1:0] RST_SORT_LIMIT   = 16'd2;

	// Controller to datapath commands; capture, exec and rd are each high for one cycle.
	typedef struct packed {
		logic capture;	// latch the accepted item
		logic exec;	// apply the item to queue and slot state
		logic rd;	// read the head entry from the store
		logic cfg_we;	// configuration transfer
	} dcrq_cmd_t;

endpackage

/* rtl/downlink_command_resend_queue.sv */
// Top level of the downlink command resend queue: controller plus datapath.
// Depends on dcrq_pkg, dcrq_ctrl and dcrq_datapath.
//
//  channel   handshake                   payload
//  -------   -------------------------   ---------------------------------------------
//  command   start & !busy               opcode, reg_class, value, delivered_ok
//  result    result_valid (1 cycle)      accepted ... resend_done (state after the item)
//  config    cfg_valid & cfg_ready       cfg_index, cfg_data
//
// The item is captured at its accepting edge; the controller then steps through execute
// (store write and pointer update), head read from the store's registered port and
// the result cycle. busy is high in all three, so a new command is taken only once
// the previous result has been shown.
// The result is shown for one cycle only; the receiver cannot stall it.
// Config writes are taken only while busy is low. Reset restores the register
// defaults and empties queue and target slot; the store itself is not cleared.
module downlink_command_resend_queue #(
	parameter int QUEUE_DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	// command channel
	input  logic                                      start,
	output logic                                      busy,
	input  logic [dcrq_pkg::OPCODE_W-1:0]             opcode,
	input  logic [dcrq_pkg::CLASS_W-1:0]              reg_class,
	input  logic [dcrq_pkg::VALUE_W-1:0]              value,
	input  logic                                      delivered_ok,
	// config channel
	input  logic                                      cfg_valid,
	output logic                                      cfg_ready,
	input  logic [dcrq_pkg::CFG_IDX_W-1:0]            cfg_index,
	input  logic [dcrq_pkg::VALUE_W-1:0]              cfg_data,
	// result channel
	output logic                                      result_valid,
	output logic                                      accepted,
	output logic                                      dropped,
	output logic                                      dropped_dest,
	output logic                                      head_valid,
	output logic                                      head_dest,
	output logic [dcrq_pkg::VALUE_W-1:0]              head_value,
	output logic                                      target_pending,
	output logic [dcrq_pkg::VALUE_W-1:0]              target_out,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]          queue_count,
	output logic                                      resend_started,
	output logic                                      resend_done
);

	dcrq_pkg::dcrq_cmd_t cmd;

	// sequencer: one command in flight, config only while idle
	dcrq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cfg_valid    (cfg_valid),
		.busy         (busy),
		.cfg_ready    (cfg_ready),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	// queue, slot and flags; outputs hold until the next command executes
	dcrq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.CNT_W       ($clog2(QUEUE_DEPTH + 1))
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.opcode         (opcode),
		.reg_class      (reg_class),
		.value          (value),
		.delivered_ok   (delivered_ok),
		.accepted       (accepted),
		.dropped        (dropped),
		.dropped_dest   (dropped_dest),
		.head_valid     (head_valid),
		.head_dest      (head_dest),
		.head_value     (head_value),
		.target_pending (target_pending),
		.target_out     (target_out),
		.queue_count    (queue_count),
		.resend_started (resend_started),
		.resend_done    (resend_done)
	);

endmodule

/* rtl/dcrq_ctrl.sv */
// Sequencer for the downlink command resend queue.
// Depends on dcrq_pkg.
module dcrq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               cfg_valid,
	output logic               busy,
	output logic               cfg_ready,
	output logic               result_valid,
	output dcrq_pkg::dcrq_cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;
	localparam logic [1:0] S_RESP = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC:  state_d = S_READ;
			S_READ:  state_d = S_RESP;
			S_RESP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign result_valid = (state_q == S_RESP);

	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.exec    = (state_q == S_EXEC);
	assign cmd.rd      = (state_q == S_READ);
	assign cmd.cfg_we  = (state_q == S_IDLE) && cfg_valid;

endmodule

/* rtl/dcrq_datapath.sv */
// Datapath: config registers, target slot, ring store with pointers, result flags.
// Depends on dcrq_pkg; driven by dcrq_ctrl commands.
module dcrq_datapath #(
	parameter int QUEUE_DEPTH = 8,
	parameter int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dcrq_pkg::dcrq_cmd_t                 cmd,
	input  logic [dcrq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dcrq_pkg::VALUE_W-1:0]        cfg_data,
	input  logic [dcrq_pkg::OPCODE_W-1:0]       opcode,
	input  logic [dcrq_pkg::CLASS_W-1:0]        reg_class,
	input  logic [dcrq_pkg::VALUE_W-1:0]        value,
	input  logic                                delivered_ok,
	output logic                                accepted,
	output logic                                dropped,
	output logic                                dropped_dest,
	output logic                                head_valid,
	output logic                                head_dest,
	output logic [dcrq_pkg::VALUE_W-1:0]        head_value,
	output logic                                target_pending,
	output logic [dcrq_pkg::VALUE_W-1:0]        target_out,
	output logic [CNT_W-1:0]                    queue_count,
	output logic                                resend_started,
	output logic                                resend_done
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	// config
	logic [dcrq_pkg::VALUE_W-1:0] allowed_mask_q, target_limit_q, sort_limit_q;

	// captured item
	logic [dcrq_pkg::OPCODE_W-1:0] op_q;
	logic [dcrq_pkg::CLASS_W-1:0]  class_q;
	logic [dcrq_pkg::VALUE_W-1:0]  value_q;
	logic                          ok_q;

	// queue and slot state
	logic [dcrq_pkg::ENTRY_W-1:0] store_q [QUEUE_DEPTH];
	logic [dcrq_pkg::ENTRY_W-1:0] head_rd_q;
	logic [PTR_W-1:0]             rd_ptr_q, wr_ptr_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         slot_full_q, resync_q;
	logic [dcrq_pkg::VALUE_W-1:0] slot_value_q;

	// result flags
	logic accepted_q, dropped_q, dropped_dest_q, started_q, done_q;

	// next-state decode
	logic                         push, pop, full, acc, tgt_wr, tgt_clr, link;
	logic [dcrq_pkg::ENTRY_W-1:0] push_entry;
	logic [CNT_W-1:0]             cnt_d;
	logic                         resync_d;
	logic [PTR_W-1:0]             rd_ptr_inc, wr_ptr_inc;

	assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
	assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
	assign full       = (cnt_q == CNT_FULL);

	always_comb begin
		push       = 1'b0;
		pop        = 1'b0;
		acc        = 1'b0;
		tgt_wr     = 1'b0;
		tgt_clr    = 1'b0;
		link       = 1'b0;
		push_entry = {dcrq_pkg::DEST_CTRL, value_q};
		case (op_q)
			dcrq_pkg::OP_HOST: begin
				case (class_q)
					dcrq_pkg::CLASS_TARGET: begin
						acc    = (value_q <= target_limit_q);
						tgt_wr = acc;
					end
					dcrq_pkg::CLASS_CTRL: begin
						acc  = ((value_q & ~allowed_mask_q) == '0);
						push = acc;
					end
					dcrq_pkg::CLASS_SORT: begin
						acc        = (value_q <= sort_limit_q);
						push       = acc;
						push_entry = {dcrq_pkg::DEST_SORT, value_q};
					end
					default: acc = 1'b0;
				endcase
			end
			dcrq_pkg::OP_LOCAL:    push    = 1'b1;
			dcrq_pkg::OP_TGT_RES:  tgt_clr = slot_full_q && ok_q;
			dcrq_pkg::OP_HEAD_RES: pop     = (cnt_q != '0) && ok_q;
			dcrq_pkg::OP_LINK_UP:  link    = 1'b1;
			default: ;
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		if (push && !full) begin
			cnt_d = cnt_q + CNT_W'(1);
		end else if (pop) begin
			cnt_d = cnt_q - CNT_W'(1);
		end
		resync_d = link ? (cnt_q != '0) : resync_q;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_mask_q <= dcrq_pkg::RST_ALLOWED_MASK;
			target_limit_q <= dcrq_pkg::RST_TARGET_LIMIT;
			sort_limit_q   <= dcrq_pkg::RST_SORT_LIMIT;
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				dcrq_pkg::CFG_ALLOWED_MASK: allowed_mask_q <= cfg_data;
				dcrq_pkg::CFG_TARGET_LIMIT: target_limit_q <= cfg_data;
				dcrq_pkg::CFG_SORT_LIMIT:   sort_limit_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// captured item, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			class_q <= reg_class;
			value_q <= value;
			ok_q    <= delivered_ok;
		end
	end

	// entry store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.exec && push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
		if (cmd.rd) begin
			head_rd_q <= store_q[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q       <= '0;
			wr_ptr_q       <= '0;
			cnt_q          <= '0;
			slot_full_q    <= 1'b0;
			slot_value_q   <= '0;
			resync_q       <= 1'b0;
			accepted_q     <= 1'b0;
			dropped_q      <= 1'b0;
			dropped_dest_q <= 1'b0;
			started_q      <= 1'b0;
			done_q         <= 1'b0;
		end else if (cmd.exec) begin
			if (push) begin
				wr_ptr_q <= wr_ptr_inc;
			end
			// overwrite of the oldest entry and a successful pop both advance the head
			if ((push && full) || pop) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			cnt_q <= cnt_d;
			if (tgt_wr) begin
				slot_full_q  <= 1'b1;
				slot_value_q <= value_q;
			end else if (tgt_clr) begin
				slot_full_q <= 1'b0;
			end
			resync_q       <= resync_d && (cnt_d != '0);
			done_q         <= resync_d && (cnt_d == '0);
			accepted_q     <= acc;
			dropped_q      <= push && full;
			dropped_dest_q <= push && full && push_entry[dcrq_pkg::VALUE_W];
			started_q      <= link;
		end
	end

	assign accepted       = accepted_q;
	assign dropped        = dropped_q;
	assign dropped_dest   = dropped_dest_q;
	assign head_valid     = (cnt_q != '0);
	assign head_dest      = head_valid && head_rd_q[dcrq_pkg::VALUE_W];
	assign head_value     = head_valid ? head_rd_q[dcrq_pkg::VALUE_W-1:0] : '0;
	assign target_pending = slot_full_q;
	assign target_out     = slot_value_q;
	assign queue_count    = cnt_q;
	assign resend_started = started_q;
	assign resend_done    = done_q;

endmodule

/* rtl/dcrq_checker.sv */
// Port-level checks for downlink_command_resend_queue, attached by bind.
// Depends on downlink_command_resend_queue_assert.svh.
`include "downlink_command_resend_queue_assert.svh"

module dcrq_checker #(
	parameter int CNT_W = 4
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             result_valid,
	input logic             dropped,
	input logic             head_valid,
	input logic             resend_done,
	input logic [CNT_W-1:0] queue_count
);

	// a command transfer yields its result strobe once the execute and head-read states have passed
	`DCRQ_ASSERT_NOW(a_result_latency, clk, arst_n, start && !busy, ##3 result_valid)

	// head is present exactly when entries are counted
	`DCRQ_ASSERT_NOW(a_head_count, clk, arst_n, result_valid, head_valid == (queue_count != '0))

	// an overwrite leaves a full, non-empty queue
	`DCRQ_ASSERT_NOW(a_drop_head, clk, arst_n, result_valid && dropped, head_valid)

	// resync done only reported with the queue drained
	`DCRQ_ASSERT_NOW(a_done_empty, clk, arst_n, result_valid && resend_done, queue_count == '0)

	// strobe lasts one cycle
	`DCRQ_ASSERT_NEXT(a_strobe_pulse, clk, arst_n, result_valid, !result_valid)

endmodule

bind downlink_command_resend_queue dcrq_checker #(
	.CNT_W ($clog2(QUEUE_DEPTH + 1))
) u_dcrq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid),
	.dropped      (dropped),
	.head_valid   (head_valid),
	.resend_done  (resend_done),
	.queue_count  (queue_count)
);

/* tb/tb_downlink_command_resend_queue.sv */
// Self-checking testbench for downlink_command_resend_queue: directed and random
// commands, register writes between phases, results checked against a local predictor.
// Depends on dcrq_pkg and the downlink_command_resend_queue RTL.
module tb_downlink_command_resend_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import dcrq_pkg::*;

	localparam int QDEPTH      = 8;
	localparam int COUNT_W     = $clog2(QDEPTH + 1);
	localparam int CYCLE_LIMIT = 200000;	// well above the slowest legal run
	localparam int DRAIN_WAIT  = 8;

	// Opcodes and register class the block leaves unused
	localparam logic [OPCODE_W-1:0] OP_SPARE_A  = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_SPARE_B  = 3'd6;
	localparam logic [OPCODE_W-1:0] OP_SPARE_C  = 3'd7;
	localparam logic [CLASS_W-1:0]  CLASS_OTHER = 2'd3;

	typedef struct {
		logic [OPCODE_W-1:0] opcode;
		logic [CLASS_W-1:0]  reg_class;
		logic [VALUE_W-1:0]  value;
		logic                ok;
	} command_t;

	typedef struct packed {
		logic               accepted;
		logic               dropped;
		logic               dropped_dest;
		logic               head_valid;
		logic               head_dest;
		logic [VALUE_W-1:0] head_value;
		logic               target_pending;
		logic [VALUE_W-1:0] target_out;
		logic [COUNT_W-1:0] queue_count;
		logic               resend_started;
		logic               resend_done;
	} status_t;

	// ------------------------------------------------------------------
	// Clock, reset and DUT ports; every input known from time zero
	// ------------------------------------------------------------------
	logic clk;
	logic arst_n = 1'b0;

	logic                 start = 1'b0;
	logic                 busy;
	logic [OPCODE_W-1:0]  opcode = '0;
	logic [CLASS_W-1:0]   reg_class = '0;
	logic [VALUE_W-1:0]   value = '0;
	logic                 delivered_ok = 1'b0;

	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [VALUE_W-1:0]   cfg_data = '0;

	logic                 result_valid;
	logic                 accepted;
	logic                 dropped;
	logic                 dropped_dest;
	logic                 head_valid;
	logic                 head_dest;
	logic [VALUE_W-1:0]   head_value;
	logic                 target_pending;
	logic [VALUE_W-1:0]   target_out;
	logic [COUNT_W-1:0]   queue_count;
	logic                 resend_started;
	logic                 resend_done;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	downlink_command_resend_queue #(.QUEUE_DEPTH(QDEPTH)) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.reg_class      (reg_class),
		.value          (value),
		.delivered_ok   (delivered_ok),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.result_valid   (result_valid),
		.accepted       (accepted),
		.dropped        (dropped),
		.dropped_dest   (dropped_dest),
		.head_valid     (head_valid),
		.head_dest      (head_dest),
		.head_value     (head_value),
		.target_pending (target_pending),
		.target_out     (target_out),
		.queue_count    (queue_count),
		.resend_started (resend_started),
		.resend_done    (resend_done)
	);

	// ------------------------------------------------------------------
	// Predictor state: register copies, command ring, target slot, resync
	// ------------------------------------------------------------------
	logic [VALUE_W-1:0] allowed_mask;
	logic [VALUE_W-1:0] target_max;
	logic [VALUE_W-1:0] sort_max;

	logic [ENTRY_W-1:0] ring [QDEPTH];
	int                 rd_idx;
	int                 wr_idx;
	int                 fill_level;
	logic               slot_full;
	logic [VALUE_W-1:0] slot_value;
	logic               resync_pending;

	command_t cmd_backlog[$];	// commands waiting for the driver
	status_t  status_due[$];	// predicted status, oldest first

	int  sender_idle_pct = 0;
	bit  cmd_fire = 1'b0;	// command transfer at the last rising edge
	int  errors = 0;
	int  cycles = 0;
	int  n_commands = 0;
	int  n_overwrites = 0;
	int  n_resync_done = 0;
	int  n_rejected = 0;

	// Push onto the ring; a full ring loses its oldest entry
	function automatic logic ring_push(input logic [ENTRY_W-1:0] entry);
		logic overwrite = 1'b0;
		if (fill_level == QDEPTH) begin
			rd_idx     = (rd_idx + 1) % QDEPTH;
			fill_level = QDEPTH - 1;
			overwrite  = 1'b1;
		end
		ring[wr_idx] = entry;
		wr_idx       = (wr_idx + 1) % QDEPTH;
		fill_level++;
		return overwrite;
	endfunction

	// Apply one command to the predictor and return the status the block must show
	function automatic status_t predict_status(input command_t c);
		status_t            s = '0;
		logic [ENTRY_W-1:0] head;
		case (c.opcode)
			OP_HOST: begin
				case (c.reg_class)
					CLASS_TARGET: begin
						if (c.value <= target_max) begin
							s.accepted = 1'b1;
							slot_full  = 1'b1;
							slot_value = c.value;
						end
					end
					CLASS_CTRL: begin
						if ((c.value & ~allowed_mask) == '0) begin
							s.accepted = 1'b1;
							s.dropped  = ring_push({DEST_CTRL, c.value});
						end
					end
					CLASS_SORT: begin
						if (c.value <= sort_max) begin
							s.accepted     = 1'b1;
							s.dropped      = ring_push({DEST_SORT, c.value});
							s.dropped_dest = s.dropped;
						end
					end
					default: ;	// other registers: rejected, no effect
				endcase
			end
			OP_LOCAL: s.dropped = ring_push({DEST_CTRL, c.value});
			OP_TGT_RES: begin
				if (slot_full && c.ok)
					slot_full = 1'b0;
			end
			OP_HEAD_RES: begin
				if (fill_level > 0 && c.ok) begin
					rd_idx = (rd_idx + 1) % QDEPTH;
					fill_level--;
				end
			end
			OP_LINK_UP: begin
				s.resend_started = 1'b1;
				resync_pending   = (fill_level > 0);
			end
			default: ;	// spare opcodes only report state
		endcase

		// resync completes whenever the ring is seen empty
		if (resync_pending && fill_level == 0) begin
			resync_pending = 1'b0;
			s.resend_done  = 1'b1;
		end

		if (fill_level > 0) begin
			head         = ring[rd_idx];
			s.head_valid = 1'b1;
			s.head_dest  = head[ENTRY_W-1];
			s.head_value = head[VALUE_W-1:0];
		end
		s.target_pending = slot_full;
		s.target_out     = slot_value;
		s.queue_count    = COUNT_W'(fill_level);
		return s;
	endfunction

	task automatic compare_field(input string field, input logic [VALUE_W-1:0] want,
		input logic [VALUE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
			errors++;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: presents commands at the falling edge. A command is held
	// until the rising edge that takes it (start & !busy), then the next
	// one is offered or start drops while the sender idles at random.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		command_t nxt;
		if (!arst_n)
			start <= 1'b0;
		else if (!start || cmd_fire) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct) begin
				nxt = cmd_backlog.pop_front();
				opcode       <= nxt.opcode;
				reg_class    <= nxt.reg_class;
				value        <= nxt.value;
				delivered_ok <= nxt.ok;
				start        <= 1'b1;
			end else
				start <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Monitor: at each rising edge check a result strobe, record a command
	// transfer into the predictor, and track register writes.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		status_t  got;
		status_t  want;
		command_t c;
		if (!arst_n)
			cmd_fire = 1'b0;
		else begin
			if (result_valid) begin
				got = '{accepted, dropped, dropped_dest, head_valid, head_dest, head_value,
					target_pending, target_out, queue_count, resend_started, resend_done};
				n_overwrites  += int'(got.dropped);
				n_resync_done += int'(got.resend_done);
				if (status_due.size() == 0) begin
					$display("%0t: unexpected result strobe, nothing outstanding", $time);
					errors++;
				end else begin
					want = status_due.pop_front();
					compare_field("accepted", want.accepted, got.accepted);
					compare_field("dropped", want.dropped, got.dropped);
					compare_field("dropped_dest", want.dropped_dest, got.dropped_dest);
					compare_field("head_valid", want.head_valid, got.head_valid);
					compare_field("head_dest", want.head_dest, got.head_dest);
					compare_field("head_value", want.head_value, got.head_value);
					compare_field("target_pending", want.target_pending, got.target_pending);
					compare_field("target_out", want.target_out, got.target_out);
					compare_field("queue_count", want.queue_count, got.queue_count);
					compare_field("resend_started", want.resend_started, got.resend_started);
					compare_field("resend_done", want.resend_done, got.resend_done);
				end
			end

			cmd_fire = start && !busy;
			if (cmd_fire) begin
				c = '{opcode, reg_class, value, delivered_ok};
				want = predict_status(c);
				if (c.opcode == OP_HOST && !want.accepted)
					n_rejected++;
				status_due.push_back(want);
				n_commands++;
			end

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALLOWED_MASK: allowed_mask = cfg_data;
					CFG_TARGET_LIMIT: target_max   = cfg_data;
					CFG_SORT_LIMIT:   sort_max     = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Watchdog on total run length
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic add_cmd(input logic [OPCODE_W-1:0] op, input logic [CLASS_W-1:0] cls,
		input logic [VALUE_W-1:0] val, input logic ok);
		command_t c;
		c = '{op, cls, val, ok};
		cmd_backlog.push_back(c);
	endtask

	// Wait until the driver has nothing left and every result has been checked
	task automatic wait_drained();
		do
			@(posedge clk);
		while (cmd_backlog.size() != 0 || start || status_due.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// One register write transfer; only called while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VALUE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Value for a host write: mostly legal under the current registers,
	// sometimes exactly at the limit, otherwise anything in 16 bits.
	function automatic logic [VALUE_W-1:0] host_value(input logic [CLASS_W-1:0] cls);
		int unsigned roll = $urandom_range(7, 0);
		if (roll < 2 || cls == CLASS_OTHER)
			return VALUE_W'($urandom);
		case (cls)
			CLASS_TARGET: return (roll == 7) ? target_max : VALUE_W'($urandom_range(target_max, 0));
			CLASS_CTRL:   return (roll == 7) ? allowed_mask : VALUE_W'($urandom) & allowed_mask;
			default:      return (roll == 7) ? sort_max : VALUE_W'($urandom_range(sort_max, 0));
		endcase
	endfunction

	// Random commands in blocks of 16 with a traffic mix per block:
	// fill-heavy blocks push past the ring depth, drain-heavy blocks pop
	// and raise link-up so resync runs to completion, mixed blocks do both.
	task automatic queue_random(input int n);
		int             k;
		int             mix;
		int             pick;
		logic [CLASS_W-1:0] cls;
		for (k = 0; k < n; k++) begin
			if (k % 16 == 0)
				mix = $urandom_range(2, 0);
			pick = $urandom_range(99, 0);
			cls  = CLASS_W'($urandom_range(3, 0));
			if (mix == 0) begin
				if (pick < 45) begin
					cls = (pick < 20) ? CLASS_CTRL : (pick < 38) ? CLASS_SORT : cls;
					add_cmd(OP_HOST, cls, host_value(cls), $urandom_range(1, 0));
				end else if (pick < 80)
					add_cmd(OP_LOCAL, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 90)
					add_cmd(OP_HEAD_RES, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 95)
					add_cmd(OP_TGT_RES, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else
					add_cmd(OP_LINK_UP, cls, VALUE_W'($urandom), $urandom_range(1, 0));
			end else if (mix == 1) begin
				if (pick < 50)
					add_cmd(OP_HEAD_RES, cls, VALUE_W'($urandom), $urandom_range(99, 0) < 85);
				else if (pick < 65)
					add_cmd(OP_LINK_UP, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 80)
					add_cmd(OP_HOST, cls, host_value(cls), $urandom_range(1, 0));
				else if (pick < 90)
					add_cmd(OP_TGT_RES, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 95)
					add_cmd(OP_LOCAL, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else
					add_cmd(OPCODE_W'($urandom_range(OP_SPARE_C, OP_SPARE_A)), cls,
						VALUE_W'($urandom), $urandom_range(1, 0));
			end else begin
				if (pick < 35)
					add_cmd(OP_HOST, cls, host_value(cls), $urandom_range(1, 0));
				else if (pick < 50)
					add_cmd(OP_LOCAL, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 62)
					add_cmd(OP_TGT_RES, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 84)
					add_cmd(OP_HEAD_RES, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else if (pick < 94)
					add_cmd(OP_LINK_UP, cls, VALUE_W'($urandom), $urandom_range(1, 0));
				else
					add_cmd(OPCODE_W'($urandom_range(OP_SPARE_C, OP_SPARE_A)), cls,
						VALUE_W'($urandom), $urandom_range(1, 0));
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		// predictor starts from the block's reset state
		allowed_mask   = RST_ALLOWED_MASK;
		target_max     = RST_TARGET_LIMIT;
		sort_max       = RST_SORT_LIMIT;
		rd_idx         = 0;
		wr_idx         = 0;
		fill_level     = 0;
		slot_full      = 1'b0;
		slot_value     = '0;
		resync_pending = 1'b0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Phase 1: reset registers, sender idles now and then
		sender_idle_pct = 19;
		add_cmd(OP_HEAD_RES, CLASS_TARGET, 16'h0000, 1'b1);	// empty ring: ignored
		add_cmd(OP_TGT_RES, CLASS_TARGET, 16'h0000, 1'b1);	// no target pending: ignored
		add_cmd(OP_LINK_UP, CLASS_TARGET, 16'h0000, 1'b0);	// empty ring: no resync
		add_cmd(OP_HOST, CLASS_TARGET, RST_TARGET_LIMIT, 1'b0);	// at limit
		add_cmd(OP_HOST, CLASS_TARGET, RST_TARGET_LIMIT + 16'd1, 1'b0);	// one above
		add_cmd(OP_TGT_RES, CLASS_TARGET, 16'h0000, 1'b0);	// failed: stays pending
		add_cmd(OP_TGT_RES, CLASS_TARGET, 16'h0000, 1'b1);	// delivered
		add_cmd(OP_HOST, CLASS_TARGET, 16'h0000, 1'b1);	// new target of zero into the empty slot
		add_cmd(OP_HOST, CLASS_CTRL, RST_ALLOWED_MASK, 1'b0);
		add_cmd(OP_HOST, CLASS_CTRL, 16'h0008, 1'b0);	// bit outside the mask
		add_cmd(OP_HOST, CLASS_CTRL, 16'hFFFF, 1'b1);
		add_cmd(OP_HOST, CLASS_SORT, RST_SORT_LIMIT, 1'b0);
		add_cmd(OP_HOST, CLASS_SORT, RST_SORT_LIMIT + 16'd1, 1'b0);
		add_cmd(OP_HOST, CLASS_OTHER, 16'hFFFF, 1'b1);	// other register: rejected
		add_cmd(OP_LOCAL, CLASS_OTHER, 16'hFFFF, 1'b0);	// no value check
		add_cmd(OP_SPARE_A, CLASS_CTRL, 16'h5555, 1'b1);
		add_cmd(OP_SPARE_B, CLASS_SORT, 16'hAAAA, 1'b0);
		add_cmd(OP_SPARE_C, CLASS_OTHER, 16'hFFFF, 1'b1);
		add_cmd(OP_LINK_UP, CLASS_TARGET, 16'h0000, 1'b1);	// three queued: resync armed
		add_cmd(OP_HEAD_RES, CLASS_TARGET, 16'h0000, 1'b0);	// failed: head kept
		add_cmd(OP_HEAD_RES, CLASS_TARGET, 16'h0000, 1'b1);
		add_cmd(OP_LINK_UP, CLASS_TARGET, 16'h0000, 1'b1);	// restart while active
		add_cmd(OP_HEAD_RES, CLASS_TARGET, 16'h0000, 1'b1);
		add_cmd(OP_HEAD_RES, CLASS_TARGET, 16'h0000, 1'b1);	// ring empties: done pulse
		queue_random(250);
		wait_drained();

		// Phase 2: every register at its top value, sender idles often
		write_reg(CFG_ALLOWED_MASK, 16'hFFFF);
		write_reg(CFG_TARGET_LIMIT, 16'hFFFF);
		write_reg(CFG_SORT_LIMIT, 16'hFFFF);
		sender_idle_pct = 53;
		queue_random(250);
		wait_drained();

		// Phase 3: every register at zero, back-to-back commands
		write_reg(CFG_ALLOWED_MASK, 16'h0000);
		write_reg(CFG_TARGET_LIMIT, 16'h0000);
		write_reg(CFG_SORT_LIMIT, 16'h0000);
		sender_idle_pct = 0;
		queue_random(250);
		wait_drained();

		// Phase 4: mid-range settings with a sparse mask
		write_reg(CFG_ALLOWED_MASK, 16'h80F5);
		write_reg(CFG_TARGET_LIMIT, 16'd500);
		write_reg(CFG_SORT_LIMIT, 16'd9);
		queue_random(250);
		wait_drained();

		$display("Checked %0d commands under four register settings with varied sender gaps.",
			n_commands);
		$display("Seen: %0d ring overwrites, %0d resync completions, %0d rejected host writes.",
			n_overwrites, n_resync_done, n_rejected);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
